FILE: hdl/kec_pkg.sv
// Shared types, keyword dictionary and byte helpers for the keyword emotion classifier.
package kec_pkg;

    localparam int WINDOW_LEN = 13;
    localparam int SEEN_W     = 4;
    localparam int KW_COUNT   = 25;
    localparam int KW_MAX_LEN = 12;
    localparam int KW_BITS    = 8 * KW_MAX_LEN;
    localparam int CAT_COUNT  = 5;

    localparam logic [SEEN_W-1:0] SEEN_MAX = '1;

    // Result codes
    localparam logic [2:0] CLASS_NEUTRAL  = 3'd0;
    localparam logic [2:0] CLASS_HAPPY    = 3'd1;
    localparam logic [2:0] CLASS_STRESSED = 3'd2;
    localparam logic [2:0] CLASS_SAD      = 3'd3;
    localparam logic [2:0] CLASS_ANGRY    = 3'd4;
    localparam logic [2:0] CLASS_CALM     = 3'd5;

    localparam logic [2:0] CONF_HIT  = 3'd7;
    localparam logic [2:0] CONF_MISS = 3'd5;

    // Category hit bits
    localparam logic [2:0] CAT_HAPPY    = 3'd0;
    localparam logic [2:0] CAT_STRESSED = 3'd1;
    localparam logic [2:0] CAT_SAD      = 3'd2;
    localparam logic [2:0] CAT_ANGRY    = 3'd3;
    localparam logic [2:0] CAT_CALM     = 3'd4;

    // Keywords are right-justified: byte j of an entry is its last letter minus j,
    // which lines up with window tap j (tap 0 is the newest byte).
    localparam logic [KW_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        "happy", "excited", "great", "amazing", "love", "wonderful", "fantastic",
        "stressed", "worried", "anxious", "overwhelmed", "pressure",
        "sad", "disappointed", "miss", "lonely", "depressed",
        "angry", "mad", "frustrated", "furious",
        "calm", "relaxed", "peaceful", "chill"
    };

    localparam int KW_LEN [KW_COUNT] = '{
        5, 7, 5, 7, 4, 9, 9,
        8, 7, 7, 11, 8,
        3, 12, 4, 6, 9,
        5, 3, 10, 7,
        4, 7, 8, 5
    };

    localparam logic [2:0] KW_CAT [KW_COUNT] = '{
        CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY,
        CAT_STRESSED, CAT_STRESSED, CAT_STRESSED, CAT_STRESSED, CAT_STRESSED,
        CAT_SAD, CAT_SAD, CAT_SAD, CAT_SAD, CAT_SAD,
        CAT_ANGRY, CAT_ANGRY, CAT_ANGRY, CAT_ANGRY,
        CAT_CALM, CAT_CALM, CAT_CALM, CAT_CALM
    };

    // One window position as seen by the matcher
    typedef struct packed {
        logic [7:0] ch;     // case-folded byte
        logic       alnum;  // 0-9, A-Z or a-z
    } kec_tap_t;

    function automatic logic is_alnum(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h41) && (c <= 8'h5A)) ||
               ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if ((c >= 8'h41) && (c <= 8'h5A)) begin
            return c + 8'd32;
        end
        return c;
    endfunction

endpackage

FILE: hdl/kec_cell.sv
// One window cell: holds a folded byte and passes it on to the next cell.
module kec_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              shift_en,
    input  logic              clear,
    input  logic [7:0]        ch_in,
    output kec_pkg::kec_tap_t tap
);
    import kec_pkg::*;

    logic [7:0] ch_reg;
    logic [7:0] ch_next;

    always_comb begin
        ch_next = ch_reg;
        if (clear) begin
            ch_next = 8'd0;
        end else if (shift_en) begin
            ch_next = ch_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ch_reg <= 8'd0;
        end else begin
            ch_reg <= ch_next;
        end
    end

    assign tap.ch    = ch_reg;
    assign tap.alnum = is_alnum(ch_reg);

endmodule

FILE: hdl/kec_match.sv
// Parallel whole-word keyword compare over the window taps.
module kec_match (
    input  kec_pkg::kec_tap_t              taps [kec_pkg::WINDOW_LEN],
    input  logic [kec_pkg::SEEN_W-1:0]     seen,
    output logic [kec_pkg::CAT_COUNT-1:0]  hits
);
    import kec_pkg::*;

    logic [KW_COUNT-1:0] kw_hit;

    for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
        localparam int N = KW_LEN[k];
        logic [N-1:0] eq;

        for (genvar j = 0; j < N; j++) begin : g_ch
            assign eq[j] = (taps[j].ch == KW_TEXT[k][8*j +: 8]);
        end

        // word must start at text start or just after a non-alnum byte
        assign kw_hit[k] = (seen >= SEEN_W'(N)) && (&eq) &&
                           ((seen == SEEN_W'(N)) || !taps[N].alnum);
    end

    always_comb begin
        hits = '0;
        for (int k = 0; k < KW_COUNT; k++) begin
            if (kw_hit[k]) begin
                hits[KW_CAT[k]] = 1'b1;
            end
        end
    end

endmodule

FILE: hdl/keyword_emotion_classifier.sv
// Top level of the keyword emotion classifier: window cell chain, matcher, result register.
//
// Usage:
//   Input channel (s_*): one text byte per request. s_has_char marks a real
//   byte; s_end_of_text marks the last request of a text. A request with
//   s_has_char = 0 and s_end_of_text = 0 is ignored; with s_end_of_text = 1
//   it closes the text without adding a byte (an empty text gives neutral).
//   Result channel (m_*): one request per text, issued for the request that
//   carries s_end_of_text: m_emotion_class (0 neutral, 1 happy, 2 stressed,
//   3 sad, 4 angry, 5 calm, first hit in that order) and m_confidence_tenths
//   (7 on a keyword hit, else 5).
// Timing:
//   One input request per cycle, sustained while s_ready is high. The result is valid the cycle
//   after the final byte is taken. All 25 keywords are compared at once
//   against the 13-cell byte window, so the match is done in the same cycle.
// Reset and stall:
//   Synchronous active-low reset clears the window, byte count, hit flags and
//   the result register. While a result is held and m_ready is low, s_ready
//   stays low; it rises again in the cycle the receiver takes the result.
//   After each result the per-text state returns to its reset values.
module keyword_emotion_classifier (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_text_byte,
    input  logic       s_has_char,
    input  logic       s_end_of_text,
    input  logic       s_valid,
    output logic       s_ready,
    output logic [2:0] m_emotion_class,
    output logic [2:0] m_confidence_tenths,
    output logic       m_valid,
    input  logic       m_ready
);
    import kec_pkg::*;

    // Per-text state
    logic [SEEN_W-1:0]    seen_reg, seen_next;
    logic [CAT_COUNT-1:0] hits_reg, hits_next;

    // Result register
    logic       m_valid_reg, m_valid_next;
    logic [2:0] m_class_reg, m_class_next;
    logic [2:0] m_conf_reg,  m_conf_next;

    logic                 s_accept;
    logic                 in_alnum;
    logic [7:0]           in_folded;
    logic                 use_shifted;
    logic                 do_test;
    logic [SEEN_W-1:0]    seen_inc;
    logic [SEEN_W-1:0]    view_seen;
    logic [CAT_COUNT-1:0] match_hits;
    logic [CAT_COUNT-1:0] final_hits;
    logic                 cell_shift;
    logic                 cell_clear;

    kec_tap_t cell_tap [WINDOW_LEN];
    kec_tap_t view_tap [WINDOW_LEN];

    // Output register parts the two channels: input stalls only when a
    // finished result is still held and the receiver is not taking it.
    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign in_folded = fold_case(s_text_byte);
    assign in_alnum  = is_alnum(s_text_byte);
    assign seen_inc  = (seen_reg == SEEN_MAX) ? seen_reg : seen_reg + SEEN_W'(1);

    // A non-alnum byte tests the window before it shifts in. At end of text
    // the test sees the window after an alnum byte; after a non-alnum last
    // byte the post-shift test can never hit, so the pre-shift test covers it.
    assign use_shifted = s_has_char && in_alnum;
    assign do_test     = s_end_of_text || (s_has_char && !in_alnum);
    assign view_seen   = use_shifted ? seen_inc : seen_reg;

    assign cell_shift = s_accept && s_has_char;
    assign cell_clear = s_accept && s_end_of_text;

    // Cell chain: cell 0 takes the folded input byte, each next cell its neighbor.
    for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
        logic [7:0] ch_in;
        if (i == 0) begin : g_head
            assign ch_in = in_folded;
        end else begin : g_link
            assign ch_in = cell_tap[i-1].ch;
        end

        kec_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .shift_en (cell_shift),
            .clear    (cell_clear),
            .ch_in    (ch_in),
            .tap      (cell_tap[i])
        );

        // Matcher view: either the current window or the window with the
        // incoming byte already shifted in.
        if (i == 0) begin : g_view_head
            assign view_tap[i] = use_shifted ? kec_tap_t'{ch: in_folded, alnum: in_alnum}
                                             : cell_tap[i];
        end else begin : g_view_link
            assign view_tap[i] = use_shifted ? cell_tap[i-1] : cell_tap[i];
        end
    end

    kec_match u_match (
        .taps (view_tap),
        .seen (view_seen),
        .hits (match_hits)
    );

    assign final_hits = hits_reg | (do_test ? match_hits : '0);

    always_comb begin
        seen_next = seen_reg;
        hits_next = hits_reg;
        if (s_accept) begin
            if (s_end_of_text) begin
                seen_next = '0;
                hits_next = '0;
            end else begin
                hits_next = final_hits;
                if (s_has_char) begin
                    seen_next = seen_inc;
                end
            end
        end
    end

    // Result: first category with a hit, happy first
    always_comb begin
        m_valid_next = m_valid_reg;
        m_class_next = m_class_reg;
        m_conf_next  = m_conf_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (s_accept && s_end_of_text) begin
            m_valid_next = 1'b1;
            m_conf_next  = CONF_HIT;
            priority if (final_hits[CAT_HAPPY]) begin
                m_class_next = CLASS_HAPPY;
            end else if (final_hits[CAT_STRESSED]) begin
                m_class_next = CLASS_STRESSED;
            end else if (final_hits[CAT_SAD]) begin
                m_class_next = CLASS_SAD;
            end else if (final_hits[CAT_ANGRY]) begin
                m_class_next = CLASS_ANGRY;
            end else if (final_hits[CAT_CALM]) begin
                m_class_next = CLASS_CALM;
            end else begin
                m_class_next = CLASS_NEUTRAL;
                m_conf_next  = CONF_MISS;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg    <= '0;
            hits_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_class_reg <= CLASS_NEUTRAL;
            m_conf_reg  <= CONF_MISS;
        end else begin
            seen_reg    <= seen_next;
            hits_reg    <= hits_next;
            m_valid_reg <= m_valid_next;
            m_class_reg <= m_class_next;
            m_conf_reg  <= m_conf_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_emotion_class     = m_class_reg;
    assign m_confidence_tenths = m_conf_reg;

endmodule

FILE: sim/tb_keyword_emotion_classifier.sv
// Self-checking testbench for the keyword emotion classifier: random texts, stalls, scoreboard.
module tb_keyword_emotion_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import kec_pkg::*;

    // Own copy of the block's geometry and dictionary
    localparam int WIN_DEPTH   = 13;
    localparam int KW_TOTAL    = 25;
    localparam int CYCLE_LIMIT = 100000;
    localparam int HOLD_AT     = 300;   // receiver stall starts after this many requests
    localparam int HOLD_LEN    = 400;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       has_char;
        logic       end_of_text;
    } text_req_t;

    typedef struct packed {
        logic [2:0] emo;
        logic [2:0] conf;
    } verdict_t;

    string kw_words [KW_TOTAL] = '{
        "happy", "excited", "great", "amazing", "love", "wonderful", "fantastic",
        "stressed", "worried", "anxious", "overwhelmed", "pressure",
        "sad", "disappointed", "miss", "lonely", "depressed",
        "angry", "mad", "frustrated", "furious",
        "calm", "relaxed", "peaceful", "chill"
    };

    logic [2:0] kw_cat [KW_TOTAL] = '{
        CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY, CAT_HAPPY,
        CAT_STRESSED, CAT_STRESSED, CAT_STRESSED, CAT_STRESSED, CAT_STRESSED,
        CAT_SAD, CAT_SAD, CAT_SAD, CAT_SAD, CAT_SAD,
        CAT_ANGRY, CAT_ANGRY, CAT_ANGRY, CAT_ANGRY,
        CAT_CALM, CAT_CALM, CAT_CALM, CAT_CALM
    };

    // DUT ports, all known from time zero
    logic       aclk                = 1'b0;
    logic       aresetn             = 1'b0;
    logic [7:0] s_text_byte         = 8'h00;
    logic       s_has_char          = 1'b0;
    logic       s_end_of_text       = 1'b0;
    logic       s_valid             = 1'b0;
    logic       s_ready;
    logic [2:0] m_emotion_class;
    logic [2:0] m_confidence_tenths;
    logic       m_valid;
    logic       m_ready             = 1'b0;

    keyword_emotion_classifier uut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_text_byte         (s_text_byte),
        .s_has_char          (s_has_char),
        .s_end_of_text       (s_end_of_text),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .m_emotion_class     (m_emotion_class),
        .m_confidence_tenths (m_confidence_tenths),
        .m_valid             (m_valid),
        .m_ready             (m_ready)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Stimulus and scoreboard storage
    text_req_t pending_reqs [$];
    verdict_t  expected_verdicts [$];

    int accepted_reqs  = 0;
    int texts_closed   = 0;
    int verdicts_seen  = 0;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int reqs_built     = 0;   // requests that carry a byte or close a text
    int hold_left      = 0;
    bit hold_done      = 1'b0;

    // A stretch in the middle where neither side idles
    logic steady_phase;
    assign steady_phase = (accepted_reqs >= 700) && (accepted_reqs < 1000);

    // ---------------------------------------------------------------
    // Predictor state: byte window (tap 0 newest), saturating byte
    // count, one hit flag per category.
    // ---------------------------------------------------------------
    logic [7:0] win_bytes [WIN_DEPTH];
    logic [3:0] seen_count = 4'd0;
    logic [4:0] cat_hits   = 5'd0;

    initial begin
        for (int i = 0; i < WIN_DEPTH; i++) begin
            win_bytes[i] = 8'h00;
        end
    end

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic [7:0] lower_byte(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    // Keyword k ends at tap 0 and starts on a word boundary
    function automatic bit word_ends_here(input int k);
        int n;
        n = kw_words[k].len();
        if (n >= WIN_DEPTH || seen_count < n) begin
            return 1'b0;
        end
        for (int i = 0; i < n; i++) begin
            if (lower_byte(win_bytes[n - 1 - i]) != kw_words[k][i]) begin
                return 1'b0;
            end
        end
        return (seen_count == n) || !is_word_char(win_bytes[n]);
    endfunction

    task automatic scan_keywords();
        for (int k = 0; k < KW_TOTAL; k++) begin
            if (word_ends_here(k)) begin
                cat_hits[kw_cat[k]] = 1'b1;
            end
        end
    endtask

    // First category hit wins, in priority order
    function automatic verdict_t pick_verdict(input logic [4:0] hits);
        verdict_t v;
        v.conf = CONF_HIT;
        if (hits[CAT_HAPPY]) begin
            v.emo = CLASS_HAPPY;
        end else if (hits[CAT_STRESSED]) begin
            v.emo = CLASS_STRESSED;
        end else if (hits[CAT_SAD]) begin
            v.emo = CLASS_SAD;
        end else if (hits[CAT_ANGRY]) begin
            v.emo = CLASS_ANGRY;
        end else if (hits[CAT_CALM]) begin
            v.emo = CLASS_CALM;
        end else begin
            v.emo  = CLASS_NEUTRAL;
            v.conf = CONF_MISS;
        end
        return v;
    endfunction

    // Apply one accepted request to the predictor
    task automatic absorb_request(input logic [7:0] b, input logic hc, input logic eot);
        if (hc) begin
            // a boundary byte closes the word that sits in the window
            if (!is_word_char(b)) begin
                scan_keywords();
            end
            for (int i = WIN_DEPTH - 1; i > 0; i--) begin
                win_bytes[i] = win_bytes[i - 1];
            end
            win_bytes[0] = b;
            if (seen_count != 4'hF) begin
                seen_count = seen_count + 4'd1;
            end
        end
        if (eot) begin
            // end of text is a boundary too
            scan_keywords();
            expected_verdicts.push_back(pick_verdict(cat_hits));
            texts_closed++;
            for (int i = 0; i < WIN_DEPTH; i++) begin
                win_bytes[i] = 8'h00;
            end
            seen_count = 4'd0;
            cat_hits   = 5'd0;
        end
    endtask

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    endtask

    // ---------------------------------------------------------------
    // Request driver: pops the pending queue, holds payload until the
    // handshake, idles at random outside the steady stretch.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : req_driver
        text_req_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                absorb_request(s_text_byte, s_has_char, s_end_of_text);
                accepted_reqs <= accepted_reqs + 1;
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() != 0 && (steady_phase || $urandom_range(99) >= 33)) begin
                    nxt = pending_reqs.pop_front();
                    s_text_byte   <= nxt.text_byte;
                    s_has_char    <= nxt.has_char;
                    s_end_of_text <= nxt.end_of_text;
                    s_valid       <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here; the sender keeps offering so
    // the result register fills and s_ready must drop.
    always @(posedge aclk) begin : rx_hold_ctrl
        if (!hold_done && accepted_reqs >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: each accepted result against the oldest
    // expectation, field by field.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin : result_monitor
        verdict_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                verdicts_seen <= verdicts_seen + 1;
                if (expected_verdicts.size() == 0) begin
                    flag_mismatch("unexpected result, class", m_emotion_class, -1);
                end else begin
                    want = expected_verdicts.pop_front();
                    if (m_emotion_class !== want.emo) begin
                        flag_mismatch("emotion_class", m_emotion_class, want.emo);
                    end
                    if (m_confidence_tenths !== want.conf) begin
                        flag_mismatch("confidence_tenths", m_confidence_tenths, want.conf);
                    end
                end
            end
            m_ready <= (hold_left == 0) && (steady_phase || $urandom_range(99) >= 33);
        end
    end

    // Watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_verdicts.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus building
    // ---------------------------------------------------------------
    task automatic push_req(input logic [7:0] b, input logic hc, input logic eot);
        text_req_t r;
        r.text_byte   = b;
        r.has_char    = hc;
        r.end_of_text = eot;
        pending_reqs.push_back(r);
        if (hc || eot) begin
            reqs_built++;
        end
    endtask

    function automatic logic [7:0] rand_boundary_byte();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (is_word_char(c)) begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    function automatic logic [7:0] rand_word_char();
        int r;
        r = $urandom_range(61);
        if (r < 10) begin
            return 8'(48 + r);
        end else if (r < 36) begin
            return 8'(65 + r - 10);
        end
        return 8'(97 + r - 36);
    endfunction

    // Keyword in random letter case, optionally clipped by one letter
    task automatic add_keyword(ref logic [7:0] buf_q [$], input int k, input bit clip);
        logic [7:0] c;
        int n;
        n = kw_words[k].len() - (clip ? 1 : 0);
        for (int i = 0; i < n; i++) begin
            c = kw_words[k][i];
            if ($urandom_range(1)) begin
                c = c - 8'd32;
            end
            buf_q.push_back(c);
        end
    endtask

    // One random text; mostly keywords with random content around them
    task automatic add_random_text();
        logic [7:0] buf_q [$];
        int words;
        int kind;
        int k;
        words = $urandom_range(5, 1);
        if ($urandom_range(99) < 3) begin
            words = 0;   // empty text
        end
        for (int w = 0; w < words; w++) begin
            kind = $urandom_range(99);
            k    = $urandom_range(KW_TOTAL - 1);
            if (kind < 45) begin
                add_keyword(buf_q, k, 1'b0);
            end else if (kind < 50) begin
                buf_q.push_back(rand_word_char());          // glued in front
                add_keyword(buf_q, k, 1'b0);
            end else if (kind < 55) begin
                add_keyword(buf_q, k, 1'b0);
                buf_q.push_back(rand_word_char());          // glued behind
            end else if (kind < 62) begin
                add_keyword(buf_q, k, 1'b1);
            end else if (kind < 80) begin
                // random word of 1 to 16 characters, at times long enough to saturate the byte count
                for (int i = $urandom_range(16, 1); i > 0; i--) begin
                    buf_q.push_back(rand_word_char());
                end
            end else begin
                for (int i = $urandom_range(3, 1); i > 0; i--) begin
                    buf_q.push_back(rand_boundary_byte());
                end
            end
            if (w != words - 1 && $urandom_range(3) != 0) begin
                buf_q.push_back(rand_boundary_byte());
            end
        end
        if (buf_q.size() != 0 && $urandom_range(3) == 0) begin
            buf_q.push_back(rand_boundary_byte());
        end
        // close on the last byte, or with a separate byte-less request
        if (buf_q.size() == 0 || $urandom_range(3) == 0) begin
            foreach (buf_q[i]) begin
                if ($urandom_range(19) == 0) begin
                    push_req(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                push_req(buf_q[i], 1'b1, 1'b0);
            end
            push_req(8'($urandom_range(255)), 1'b0, 1'b1);
        end else begin
            foreach (buf_q[i]) begin
                if ($urandom_range(19) == 0) begin
                    push_req(8'($urandom_range(255)), 1'b0, 1'b0);
                end
                push_req(buf_q[i], 1'b1, i == buf_q.size() - 1);
            end
        end
    endtask

    task automatic push_string(input string s, input bit close_last);
        for (int i = 0; i < s.len(); i++) begin
            push_req(s[i], 1'b1, close_last && (i == s.len() - 1));
        end
    endtask

    // Sender pause: nothing new until every expected result is back
    task automatic drain_all();
        while (pending_reqs.size() != 0 || s_valid || expected_verdicts.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    initial begin : stimulus
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: ignored request, empty text, case folding at end of
        // text, extreme byte values, separate close, category priority.
        push_req(8'h41, 1'b0, 1'b0);
        push_req(8'hFF, 1'b0, 1'b1);
        push_string("Mad", 1'b1);
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h00, 1'b1, 1'b1);
        push_string("calm!", 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        push_string("sad HAPPY", 1'b1);
        drain_all();

        // Random texts in two halves with a full drain between them
        while (reqs_built < 900) begin
            add_random_text();
        end
        drain_all();
        while (reqs_built < 1760) begin
            add_random_text();
        end
        drain_all();
        repeat (10) @(negedge aclk);

        $display("Ran %0d requests forming %0d texts; %0d results compared.",
                 accepted_reqs, texts_closed, verdicts_seen);
        $display("Included a %0d-cycle receiver hold-off and %0d mismatches.",
                 HOLD_LEN, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
